// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define SACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define SACF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/sacf_pkg.sv -----
package sacf_pkg;

  // fixed field widths
  localparam int ADDR_W    = 8;
  localparam int DATA_W    = 32;
  localparam int WAY_OUT_W = 2;

  // access codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // lookup status between the way select logic and the top level
  typedef struct packed {
    logic hit;
    logic alloc;
    logic evict;
  } lookup_t;

endpackage

// ----- sv/sacf_lookup.sv -----
module sacf_lookup #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 4,
  parameter int WAY_W = 2
) (
  input  logic [WAYS-1:0]            valid_row_i,
  input  logic [WAYS-1:0][TAG_W-1:0] tag_row_i,
  input  logic [TAG_W-1:0]           tag_i,
  input  logic [WAY_W-1:0]           fifo_head_i,
  output sacf_pkg::lookup_t          status_o,
  output logic [WAY_W-1:0]           way_o
);
  import sacf_pkg::*;

  logic             hit;
  logic             free;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  // parallel tag compare, lowest matching way and lowest empty way win
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_row_i[w] && (tag_row_i[w] == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_row_i[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // way choice: hit, else first empty way, else oldest way of the set
  always_comb begin
    status_o.hit   = hit;
    status_o.alloc = !hit && free;
    status_o.evict = !hit && !free;
    if (hit) begin
      way_o = hit_way;
    end else if (free) begin
      way_o = free_way;
    end else begin
      way_o = fifo_head_i;
    end
  end

endmodule

// ----- sv/set_assoc_cache_fifo_top.sv -----
// Set-associative write-through cache of one-word lines with FIFO replacement.
// Input channel (in_valid_i/in_ready_o) takes one access per beat: func_i
// selects read or write, address_i is the word address, write_data_i the
// word for a write. Output channel (out_valid_o/out_ready_i) returns one beat
// per access in order: hit, way used, data now in the line, eviction flag and
// the line data before the access.
// An accepted access is registered in the lookup stage and then in the result
// register. Throughput is one access per cycle while the receiver keeps up; the
// set row and main store are read at accept and written as the access leaves
// the lookup stage, with a write-first bypass so that back-to-back accesses to
// the same set or word see each other. After reset all lines are invalid and the
// main store is swept to zero, one word per cycle; in_ready_o stays low meanwhile.
// When the receiver stalls, the result register holds its beat and one more
// access may be accepted into the lookup stage; further input then waits.
module set_assoc_cache_fifo_top #(
  parameter int MEM_WORDS = 256,
  parameter int SETS      = 16,
  parameter int WAYS      = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [sacf_pkg::ADDR_W-1:0]          address_i,
  input  logic signed [sacf_pkg::DATA_W-1:0]   write_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic [sacf_pkg::WAY_OUT_W-1:0]       way_o,
  output logic signed [sacf_pkg::DATA_W-1:0]   line_data_o,
  output logic                                 evicted_o,
  output logic signed [sacf_pkg::DATA_W-1:0]   old_data_o
);
  import sacf_pkg::*;

  localparam int MEM_AW   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SPAN     = (MEM_WORDS < (1 << ADDR_W)) ? MEM_WORDS : (1 << ADDR_W);
  localparam int TAG_CNT  = (SPAN + SETS - 1) / SETS;
  localparam int TAG_W    = (TAG_CNT > 1) ? $clog2(TAG_CNT) : 1;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_SH   = $clog2(SETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAYS-1:0][DATA_W-1:0] word_row_t;

  // storage
  tag_row_t               tag_mem  [SETS];
  word_row_t              word_mem [SETS];
  logic [DATA_W-1:0]      main_mem [MEM_WORDS];
  logic [SETS-1:0][WAYS-1:0]  valid_q;
  logic [SETS-1:0][WAY_W-1:0] fifo_q;

  // clearing sweep
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  // lookup stage
  logic              s1_valid_q;
  logic              s1_func_q;
  logic [SET_W-1:0]  s1_set_q;
  logic [TAG_W-1:0]  s1_tag_q;
  logic [MEM_AW-1:0] s1_maddr_q;
  logic [DATA_W-1:0] s1_wdata_q;
  tag_row_t          tag_rd_q;
  word_row_t         word_rd_q;
  logic [DATA_W-1:0] main_rd_q;

  // result register
  logic              out_valid_q;
  logic              hit_q;
  logic [WAY_W-1:0]  way_q;
  logic [DATA_W-1:0] line_q;
  logic              evict_q;
  logic [DATA_W-1:0] old_q;

  logic              in_fire;
  logic              s1_fire;
  logic [MEM_AW-1:0] in_maddr;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  lookup_t           lk;
  logic [WAY_W-1:0]  sel;
  logic [DATA_W-1:0] old_data;
  logic [DATA_W-1:0] now_data;
  tag_row_t          tag_row_new;
  word_row_t         word_row_new;
  logic              main_we;
  logic [MEM_AW-1:0] main_waddr;
  logic [DATA_W-1:0] main_wdata;
  logic [WAY_W-1:0]  fifo_next;

  // handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  // address split: wrap into memory, set is the low bits, tag the rest
  // (MEM_WORDS and SETS are powers of two)
  always_comb begin
    in_maddr = MEM_AW'(address_i);
    in_set   = SET_W'(in_maddr & MEM_AW'(SETS - 1));
    in_tag   = TAG_W'(in_maddr >> SET_SH);
  end

  sacf_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W)
  ) u_lookup (
    .valid_row_i (valid_q[s1_set_q]),
    .tag_row_i   (tag_rd_q),
    .tag_i       (s1_tag_q),
    .fifo_head_i (fifo_q[s1_set_q]),
    .status_o    (lk),
    .way_o       (sel)
  );

  // line data before and after the access
  always_comb begin
    if (lk.hit || lk.evict) begin
      old_data = word_rd_q[sel];
    end else begin
      old_data = '0;
    end
    if (s1_func_q == FUNC_WRITE) begin
      now_data = s1_wdata_q;
    end else if (lk.hit) begin
      now_data = word_rd_q[sel];
    end else begin
      now_data = main_rd_q;
    end
    tag_row_new       = tag_rd_q;
    tag_row_new[sel]  = s1_tag_q;
    word_row_new      = word_rd_q;
    word_row_new[sel] = now_data;
    fifo_next         = (sel == WAY_W'(WAYS - 1)) ? '0 : WAY_W'(sel + 1'b1);
  end

  // main store port: sweep writes zero, accesses write through
  // (a victim needs no write-back: its word already matches the store)
  always_comb begin
    main_we    = clr_busy_q || (s1_fire && (s1_func_q == FUNC_WRITE));
    main_waddr = clr_busy_q ? clr_cnt_q : s1_maddr_q;
    main_wdata = clr_busy_q ? '0 : s1_wdata_q;
  end

  // main store with write-first read
  always_ff @(posedge clk_i) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (in_fire) begin
      if (main_we && (main_waddr == in_maddr)) begin
        main_rd_q <= main_wdata;
      end else begin
        main_rd_q <= main_mem[in_maddr];
      end
    end
  end

  // set rows of tags and words with write-first read
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      tag_mem[s1_set_q]  <= tag_row_new;
      word_mem[s1_set_q] <= word_row_new;
    end
    if (in_fire) begin
      if (s1_fire && (s1_set_q == in_set)) begin
        tag_rd_q  <= tag_row_new;
        word_rd_q <= word_row_new;
      end else begin
        tag_rd_q  <= tag_mem[in_set];
        word_rd_q <= word_mem[in_set];
      end
    end
  end

  // valid bits and replacement heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fifo_q  <= '0;
    end else if (s1_fire) begin
      valid_q[s1_set_q][sel] <= 1'b1;
      if (lk.evict) begin
        fifo_q[s1_set_q] <= fifo_next;
      end
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == MEM_AW'(MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // lookup stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q  <= func_i;
      s1_set_q   <= in_set;
      s1_tag_q   <= in_tag;
      s1_maddr_q <= in_maddr;
      s1_wdata_q <= write_data_i;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      hit_q   <= lk.hit;
      way_q   <= sel;
      line_q  <= now_data;
      evict_q <= lk.evict;
      old_q   <= old_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = WAY_OUT_W'(way_q);
  assign line_data_o = line_q;
  assign evicted_o   = evict_q;
  assign old_data_o  = old_q;

endmodule

// ----- sv/sacf_checker.sv -----
`include "assert_macros.svh"

module sacf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               hit_o,
  input logic [sacf_pkg::WAY_OUT_W-1:0]     way_o,
  input logic signed [sacf_pkg::DATA_W-1:0] line_data_o,
  input logic                               evicted_o,
  input logic signed [sacf_pkg::DATA_W-1:0] old_data_o
);

  // a stalled result beat holds
  `SACF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_data_o) && $stable(way_o) && $stable(old_data_o), "result beat changed while stalled")

  // a new result traces back to an accepted beat through the lookup stage
  `SACF_ASSERT(a_out_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without an access two cycles before")

  // a hit never replaces a line
  `SACF_ASSERT(a_hit_no_evict, out_valid_o |-> !(hit_o && evicted_o), "hit reported together with eviction")

  // filling an empty way shows no previous data
  `SACF_ASSERT(a_fill_old_zero, out_valid_o && !hit_o && !evicted_o |-> old_data_o == '0, "fill of empty way with nonzero old data")

  // the store sweep keeps input closed right after reset
  `SACF_ASSERT_ALWAYS(a_reset_closed, !rst_ni |=> !in_ready_o, "input open right after reset")

endmodule

bind set_assoc_cache_fifo_top sacf_checker u_sacf_checker (.*);
